/* rtl/fps_pkg.sv */
// Shared types and constants for the frame pacing scheduler.
// Used by every module of the block; depends on nothing.
package fps_pkg;

  // Field widths fixed by the transaction format
  localparam int FRAME_W    = 48;
  localparam int SLOT_OUT_W = 3;

  // Remainder unit: bits retired per cycle and cycles per operand
  localparam int MOD_STEP   = 8;
  localparam int MOD_CYCLES = FRAME_W / MOD_STEP;

  // Remainder lanes
  localparam int NUM_LANES = 4;
  localparam int LANE_UPD  = 0;
  localparam int LANE_REN  = 1;
  localparam int LANE_PRS  = 2;
  localparam int LANE_RSZ  = 3;

  // Pacing modes (code three behaves as fixed)
  localparam logic [1:0] MODE_FIXED   = 2'd0;
  localparam logic [1:0] MODE_MAILBOX = 2'd1;
  localparam logic [1:0] MODE_BACKPR  = 2'd2;

  // Register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_BUFCNT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decide;
    logic finish;
  } fps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_done;
  } fps_sts_t;

  // One result transaction
  typedef struct packed {
    logic                  update_kick;
    logic [FRAME_W-1:0]    update_frame;
    logic [SLOT_OUT_W-1:0] update_slot;
    logic                  render_kick;
    logic [FRAME_W-1:0]    render_frame;
    logic [SLOT_OUT_W-1:0] render_slot;
    logic                  present_now;
    logic [FRAME_W-1:0]    present_frame_no;
    logic [SLOT_OUT_W-1:0] present_slot;
    logic                  resize_applied;
    logic [FRAME_W-1:0]    fill_from_frame;
    logic                  must_wait;
  } fps_res_t;

endpackage

/* rtl/fps_regs.sv */
// Configuration registers (pacing mode, buffer count) behind an APB-style port.
// Depends on fps_pkg.
module fps_regs #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [1:0]                     mode,
  output logic [$clog2(MAX_BUFFERS):0]   bc_eff,
  output logic                           cfg_clear
);

  localparam int TW = $clog2(MAX_BUFFERS) + 1;
  localparam int DW = fps_pkg::CFG_DATA_W;

  logic [1:0] mode_r;
  logic [3:0] bufcnt_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= fps_pkg::MODE_FIXED;
      bufcnt_r <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_sel)
        fps_pkg::REG_MODE:   mode_r   <= pwdata[1:0];
        fps_pkg::REG_BUFCNT: bufcnt_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // any write restarts the pacing counters
  assign cfg_clear = wr_en;

  // read mux
  always_comb begin
    unique case (reg_sel)
      fps_pkg::REG_MODE:   prdata = DW'(mode_r);
      fps_pkg::REG_BUFCNT: prdata = DW'(bufcnt_r);
      default:             prdata = '0;
    endcase
  end

  assign mode = mode_r;

  // effective buffer count: zero reads as one, clamp at the maximum
  always_comb begin
    if (bufcnt_r == 4'd0) begin
      bc_eff = TW'(1);
    end else if ({1'b0, bufcnt_r} > 5'(MAX_BUFFERS)) begin
      bc_eff = TW'(MAX_BUFFERS);
    end else begin
      bc_eff = TW'(bufcnt_r);
    end
  end

endmodule

/* rtl/fps_mod.sv */
// Multi-lane remainder unit: frame mod buffer count, MSB first, MOD_STEP bits per cycle.
// Depends on fps_pkg.
module fps_mod #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [$clog2(MAX_BUFFERS):0]      bc,
  input  logic [fps_pkg::FRAME_W-1:0]       opnd [fps_pkg::NUM_LANES],
  output logic [$clog2(MAX_BUFFERS)-1:0]    rem  [fps_pkg::NUM_LANES],
  output logic                              done
);

  localparam int RW    = $clog2(MAX_BUFFERS);
  localparam int TW    = RW + 1;
  localparam int FW    = fps_pkg::FRAME_W;
  localparam int NL    = fps_pkg::NUM_LANES;
  localparam int STEP  = fps_pkg::MOD_STEP;
  localparam int CNT_W = $clog2(fps_pkg::MOD_CYCLES + 1);

  logic [FW-1:0]    sh_r   [NL];
  logic [FW-1:0]    sh_nxt [NL];
  logic [RW-1:0]    rem_r  [NL];
  logic [RW-1:0]    rem_nxt[NL];
  logic [CNT_W-1:0] cnt_r;
  logic [TW-1:0]    t;

  // one restoring step per bit: r = (2r + bit) mod bc
  always_comb begin
    t = '0;
    for (int l = 0; l < NL; l++) begin
      rem_nxt[l] = rem_r[l];
      for (int j = 0; j < STEP; j++) begin
        t = {rem_nxt[l], sh_r[l][FW-1-j]};
        if (t >= bc) begin
          t = t - bc;
        end
        rem_nxt[l] = t[RW-1:0];
      end
      sh_nxt[l] = sh_r[l] << STEP;
    end
  end

  // cycle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(fps_pkg::MOD_CYCLES);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // operand shifters and partial remainders
  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      if (start) begin
        sh_r[l]  <= opnd[l];
        rem_r[l] <= '0;
      end else if (cnt_r != '0) begin
        sh_r[l]  <= sh_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  assign rem  = rem_r;
  assign done = (cnt_r == '0);

endmodule

/* rtl/fps_datapath.sv */
// Scheduler datapath: frame counters, per-mode decision, slot math, output register.
// Depends on fps_pkg and fps_mod.
module fps_datapath #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fps_pkg::fps_cmd_t                 cmd,
  output fps_pkg::fps_sts_t                 sts,
  input  logic                              cfg_clear,
  input  logic [1:0]                        mode,
  input  logic [$clog2(MAX_BUFFERS):0]      bc,
  input  logic                              in_uv,
  input  logic [fps_pkg::FRAME_W-1:0]       in_uf,
  input  logic                              in_rv,
  input  logic [fps_pkg::FRAME_W-1:0]       in_rf,
  input  logic                              in_rq,
  output fps_pkg::fps_res_t                 res
);

  localparam int RW  = $clog2(MAX_BUFFERS);
  localparam int TW  = RW + 1;
  localparam int FW  = fps_pkg::FRAME_W;
  localparam int NL  = fps_pkg::NUM_LANES;
  localparam int SOW = fps_pkg::SLOT_OUT_W;

  // captured transaction
  logic          uv_r, rv_r, rq_r;
  logic [FW-1:0] uf_r, rf_r;

  // pacing state
  logic [FW-1:0] prod_r, rend_r, shown_r, last_r;
  logic          has_r, infl_r, pend_r;
  logic [RW-1:0] base_r;

  // next state
  logic [FW-1:0] prod_nxt, rend_nxt, shown_nxt, last_nxt;
  logic          has_nxt, infl_nxt, pend_nxt;

  // decision terms
  logic          d_uk, d_rk, d_pk, d_rz, d_fill, d_newb, d_wait, did_p, did_r;
  logic [FW-1:0] d_uf, d_rf, d_pf, d_next;
  logic [FW-1:0] lead, pbase, ready, late_nxt;
  logic          single;

  // decision held while remainders run
  logic          uk_r, rk_r, pk_r, rz_r, fill_r, newb_r, wait_r;
  logic [FW-1:0] ufr_r, rfr_r, pfr_r, next_r;

  // remainder unit
  logic [FW-1:0] opnd [NL];
  logic [RW-1:0] rem  [NL];
  logic          mod_done;

  // slot math
  logic [RW-1:0] base_new, base_sel, slot_u, slot_r, slot_p;

  fps_pkg::fps_res_t res_r;

  function automatic logic [RW-1:0] add_mod(input logic [RW-1:0] a,
                                            input logic [RW-1:0] b,
                                            input logic [TW-1:0] m);
    logic [TW-1:0] s;
    s = TW'(a) + TW'(b);
    if (s >= m) begin
      s = s - m;
    end
    return s[RW-1:0];
  endfunction

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      uv_r <= in_uv;
      uf_r <= in_uf;
      rv_r <= in_rv;
      rf_r <= in_rf;
      rq_r <= in_rq;
    end
  end

  assign single = (bc == TW'(1));
  assign lead   = FW'(bc) - FW'(1);

  // per-mode pacing decision
  always_comb begin
    prod_nxt  = prod_r;
    rend_nxt  = rend_r;
    shown_nxt = shown_r;
    last_nxt  = last_r;
    has_nxt   = has_r;
    infl_nxt  = infl_r;
    pend_nxt  = pend_r | rq_r;
    d_uk = 1'b0; d_rk = 1'b0; d_pk = 1'b0; d_rz = 1'b0;
    d_fill = 1'b0; d_newb = 1'b0; d_wait = 1'b0;
    did_p = 1'b0; did_r = 1'b0;
    d_uf = '0; d_rf = '0; d_pf = '0; d_next = '0;
    pbase = '0; ready = '0; late_nxt = '0;

    if (single) begin
      // single buffer: everything on the current frame
      if (pend_nxt) begin
        d_rz = 1'b1; d_next = shown_r; d_newb = 1'b1; pend_nxt = 1'b0;
      end
      d_uk = 1'b1; d_uf = shown_r;
      d_rk = 1'b1; d_rf = shown_r;
      d_pk = 1'b1; d_pf = shown_r;
      shown_nxt = shown_r + FW'(1);
    end else if (mode == fps_pkg::MODE_MAILBOX) begin
      // early resize before anything was produced
      if (pend_nxt && !has_r && prod_r == '0) begin
        d_rz = 1'b1; d_next = '0; d_fill = 1'b1; d_newb = 1'b1; pend_nxt = 1'b0;
      end
      pbase = has_r ? last_r : '0;
      if (!pend_nxt && (prod_r - pbase) < lead) begin
        d_uk = 1'b1; d_uf = prod_r;
        d_rk = 1'b1; d_rf = prod_r;
        prod_nxt = prod_r + FW'(1);
      end
      if (!uv_r || !rv_r) begin
        d_wait = 1'b1;
      end else begin
        ready = (uf_r < rf_r) ? uf_r : rf_r;
        if (!has_r || ready > last_r) begin
          d_pk = 1'b1; d_pf = ready;
          last_nxt = ready; has_nxt = 1'b1; did_p = 1'b1;
        end
        // late resize once the workers drained
        late_nxt = last_nxt + FW'(1);
        if (pend_nxt && has_nxt && late_nxt == prod_nxt &&
            uf_r >= last_nxt && rf_r >= last_nxt) begin
          d_rz = 1'b1; d_next = late_nxt; d_fill = 1'b1; pend_nxt = 1'b0; did_r = 1'b1;
        end
        if (!did_p && !did_r) begin
          d_wait = 1'b1;
        end
      end
    end else if (mode == fps_pkg::MODE_BACKPR) begin
      // one frame in flight at a time
      if (!infl_r) begin
        if (pend_nxt) begin
          d_rz = 1'b1; d_next = shown_r; d_fill = 1'b1; d_newb = 1'b1; pend_nxt = 1'b0;
        end
        d_uk = 1'b1; d_uf = shown_r;
        d_rk = 1'b1; d_rf = shown_r;
        infl_nxt = 1'b1;
      end
      if (uv_r && uf_r >= shown_r && rv_r && rf_r >= shown_r) begin
        d_pk = 1'b1; d_pf = shown_r;
        shown_nxt = shown_r + FW'(1);
        infl_nxt = 1'b0;
      end else begin
        d_wait = 1'b1;
      end
    end else begin
      // fixed pacing
      if (pend_nxt && prod_r == shown_r && rend_r == shown_r) begin
        d_rz = 1'b1; d_next = shown_r; d_fill = 1'b1; d_newb = 1'b1; pend_nxt = 1'b0;
      end
      if (!pend_nxt && (prod_r - shown_r) < lead) begin
        d_uk = 1'b1; d_uf = prod_r;
        prod_nxt = prod_r + FW'(1);
      end
      if (rend_r == shown_r && rend_r < prod_nxt && uv_r && uf_r >= rend_r) begin
        d_rk = 1'b1; d_rf = rend_r;
        rend_nxt = rend_r + FW'(1);
      end
      if (rv_r && rf_r >= shown_r) begin
        d_pk = 1'b1; d_pf = shown_r;
        shown_nxt = shown_r + FW'(1);
        if (pend_nxt && prod_nxt == shown_nxt && rend_nxt == shown_nxt) begin
          d_rz = 1'b1; d_next = shown_nxt; d_fill = 1'b1; pend_nxt = 1'b0;
        end
      end else begin
        d_wait = 1'b1;
      end
    end
  end

  // pacing state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r  <= '0;
      rend_r  <= '0;
      shown_r <= '0;
      last_r  <= '0;
      has_r   <= 1'b0;
      infl_r  <= 1'b0;
      base_r  <= '0;
      pend_r  <= 1'b0;
    end else if (cfg_clear) begin
      // restart keeps the pending resize
      prod_r  <= '0;
      rend_r  <= '0;
      shown_r <= '0;
      last_r  <= '0;
      has_r   <= 1'b0;
      infl_r  <= 1'b0;
      base_r  <= '0;
    end else begin
      if (cmd.decide) begin
        prod_r  <= prod_nxt;
        rend_r  <= rend_nxt;
        shown_r <= shown_nxt;
        last_r  <= last_nxt;
        has_r   <= has_nxt;
        infl_r  <= infl_nxt;
        pend_r  <= pend_nxt;
      end
      if (cmd.finish && rz_r) begin
        base_r <= base_new;
      end
    end
  end

  // decision hold
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      uk_r   <= d_uk;
      rk_r   <= d_rk;
      pk_r   <= d_pk;
      rz_r   <= d_rz;
      fill_r <= d_fill;
      newb_r <= d_rz & d_newb;
      wait_r <= d_wait;
      ufr_r  <= d_uf;
      rfr_r  <= d_rf;
      pfr_r  <= d_pf;
      next_r <= d_next;
    end
  end

  // remainders of all frames of this decision
  assign opnd[fps_pkg::LANE_UPD] = d_uf;
  assign opnd[fps_pkg::LANE_REN] = d_rf;
  assign opnd[fps_pkg::LANE_PRS] = d_pf;
  assign opnd[fps_pkg::LANE_RSZ] = d_next;

  fps_mod #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.decide),
    .bc    (bc),
    .opnd  (opnd),
    .rem   (rem),
    .done  (mod_done)
  );

  assign sts.mod_done = mod_done;

  // realigned base: (bc - next mod bc) mod bc
  assign base_new = (rem[fps_pkg::LANE_RSZ] == '0) ? '0
                  : RW'(bc - TW'(rem[fps_pkg::LANE_RSZ]));
  // an early resize moves the base before this tick's slots
  assign base_sel = newb_r ? base_new : base_r;
  assign slot_u   = add_mod(rem[fps_pkg::LANE_UPD], base_sel, bc);
  assign slot_r   = add_mod(rem[fps_pkg::LANE_REN], base_sel, bc);
  assign slot_p   = add_mod(rem[fps_pkg::LANE_PRS], base_sel, bc);

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r.update_kick      <= uk_r;
      res_r.update_frame     <= ufr_r;
      res_r.update_slot      <= uk_r ? SOW'(slot_u) : '0;
      res_r.render_kick      <= rk_r;
      res_r.render_frame     <= rfr_r;
      res_r.render_slot      <= rk_r ? SOW'(slot_r) : '0;
      res_r.present_now      <= pk_r;
      res_r.present_frame_no <= pfr_r;
      res_r.present_slot     <= pk_r ? SOW'(slot_p) : '0;
      res_r.resize_applied   <= rz_r;
      res_r.fill_from_frame  <= fill_r ? next_r : '0;
      res_r.must_wait        <= wait_r;
    end
  end

  assign res = res_r;

endmodule

/* rtl/fps_ctrl.sv */
// Scheduler controller: sequences capture, decision, remainder wait and output load.
// Depends on fps_pkg.
module fps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fps_pkg::fps_sts_t sts,
  output fps_pkg::fps_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_MOD    = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // state sequencing
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.decide  = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a result never overwrites one still waiting
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result loaded over a waiting result");

  // capture is always followed by a decision
  a_capture_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.decide)
    else $error("decision did not follow capture");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // output valid only rises from an output load
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("output valid without a result load");

endmodule

/* rtl/frame_pacing_scheduler_top.sv */
// Frame pacing scheduler top level: register port, controller and datapath.
// Depends on fps_pkg, fps_regs, fps_ctrl, fps_datapath (and fps_mod below it).
//
//  port group   handshake                        payload
//  in_*         in_valid / in_ready              update/render done, resize request
//  out_*        out_valid / out_ready            kicks, present, resize, wait
//  APB          psel & penable & pwrite & pready paddr, pwdata, prdata
//
// From acceptance until in_ready returns, a transaction passes through capture, the decision,
// the frame-mod-buffer-count unit (48 bits at 8 per cycle) and the load of the output
// register.
// A finished result waits in the output register while the next transaction is taken;
// a new result is held back only while the previous one is still waiting.
// rst_n is synchronous: mode fixed, one buffer, pacing counters and flags and output valid cleared.
// Any register write restarts the pacing counters and keeps a pending resize.
module frame_pacing_scheduler_top #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_update_done_valid,
  input  logic [fps_pkg::FRAME_W-1:0]    in_update_done_frame,
  input  logic                           in_render_done_valid,
  input  logic [fps_pkg::FRAME_W-1:0]    in_render_done_frame,
  input  logic                           in_resize_request,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_update_kick,
  output logic [fps_pkg::FRAME_W-1:0]    out_update_frame,
  output logic [fps_pkg::SLOT_OUT_W-1:0] out_update_slot,
  output logic                           out_render_kick,
  output logic [fps_pkg::FRAME_W-1:0]    out_render_frame,
  output logic [fps_pkg::SLOT_OUT_W-1:0] out_render_slot,
  output logic                           out_present_now,
  output logic [fps_pkg::FRAME_W-1:0]    out_present_frame_no,
  output logic [fps_pkg::SLOT_OUT_W-1:0] out_present_slot,
  output logic                           out_resize_applied,
  output logic [fps_pkg::FRAME_W-1:0]    out_fill_from_frame,
  output logic                           out_must_wait,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int TW = $clog2(MAX_BUFFERS) + 1;

  logic [1:0]        mode;
  logic [TW-1:0]     bc_eff;
  logic              cfg_clear;
  fps_pkg::fps_cmd_t cmd;
  fps_pkg::fps_sts_t sts;
  fps_pkg::fps_res_t res;

  fps_regs #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .mode      (mode),
    .bc_eff    (bc_eff),
    .cfg_clear (cfg_clear)
  );

  fps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fps_datapath #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_clear (cfg_clear),
    .mode      (mode),
    .bc        (bc_eff),
    .in_uv     (in_update_done_valid),
    .in_uf     (in_update_done_frame),
    .in_rv     (in_render_done_valid),
    .in_rf     (in_render_done_frame),
    .in_rq     (in_resize_request),
    .res       (res)
  );

  // result fields
  assign out_update_kick      = res.update_kick;
  assign out_update_frame     = res.update_frame;
  assign out_update_slot      = res.update_slot;
  assign out_render_kick      = res.render_kick;
  assign out_render_frame     = res.render_frame;
  assign out_render_slot      = res.render_slot;
  assign out_present_now      = res.present_now;
  assign out_present_frame_no = res.present_frame_no;
  assign out_present_slot     = res.present_slot;
  assign out_resize_applied   = res.resize_applied;
  assign out_fill_from_frame  = res.fill_from_frame;
  assign out_must_wait        = res.must_wait;

endmodule
